[rtl/core/hdum_pkg.sv]
// ----------------------------------------------------------------------------
// hdum_pkg
// shared constants and types for the hid descriptor usage matcher
// ----------------------------------------------------------------------------
package hdum_pkg;

    // item prefix layout
    localparam logic [7:0] PREFIX_TAG_MASK  = 8'hFC;
    localparam logic [7:0] PREFIX_SIZE_MASK = 8'h03;

    // short item tags, prefix with size bits cleared
    localparam logic [7:0] TAG_USAGE_PAGE = 8'h04;
    localparam logic [7:0] TAG_USAGE      = 8'h08;
    localparam logic [7:0] TAG_COLLECTION = 8'hA0;

    // size code of a four byte item
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned USAGE_W   = 16;
    localparam int unsigned LEFT_W    = 3;
    localparam int unsigned POS_W     = 2;
    localparam int unsigned TAG_W     = 6;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // configuration register index, from paddr[2]
    typedef enum logic {
        REG_TARGET_PAGE  = 1'b0,
        REG_TARGET_USAGE = 1'b1
    } cfg_reg_t;

endpackage

[rtl/core/hid_descriptor_usage_matcher_unit.sv]
// ----------------------------------------------------------------------------
// hid_descriptor_usage_matcher_unit
// parses a hid report descriptor stream and flags a target page/usage collection
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one descriptor byte per beat in s_tdata, s_tlast marks the
//   last byte of a descriptor. m_ channel: one beat per descriptor, given
//   for the last byte only, m_tdata[0] set when a collection item was seen
//   while the current usage page and pending usage equaled the targets.
//   targets are written over the apb port (target_page at 0x0, target_usage
//   at 0x4); the user writes them only while no descriptor byte is in flight
//   to the result, which the block itself does not enforce.
// throughput: one beat per cycle in while s_tready is high; a byte is parsed
//   in the cycle it is taken, and the result beat shows on m_ in the cycle
//   after the last byte is accepted.
// reset and stall:
//   aresetn clears parse state, targets and the output valid. while a result
//   waits on m_tready, s_tready follows m_tready, so a byte is still taken
//   in the same cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module hid_descriptor_usage_matcher_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] desc_byte
    input  logic                                s_tlast,   // is_final
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [0] matched, [7:1] zero
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hdum_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hdum_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hdum_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // configuration registers
    logic [hdum_pkg::USAGE_W-1:0] target_page_reg;
    logic [hdum_pkg::USAGE_W-1:0] target_usage_reg;
    hdum_pkg::cfg_reg_t           cfg_sel;
    logic                         cfg_wr;

    // parse state; page and usage keep only the low 16 bits plus a flag that
    // is set when seen and the upper bits are zero (wider values never match)
    logic [hdum_pkg::LEFT_W-1:0]  bytes_left_reg,  bytes_left_next;
    logic [hdum_pkg::TAG_W-1:0]   item_tag_reg,    item_tag_next;
    logic [hdum_pkg::POS_W-1:0]   byte_pos_reg,    byte_pos_next;
    logic [hdum_pkg::USAGE_W-1:0] item_lo_reg,     item_lo_next;
    logic                         item_hi_nz_reg,  item_hi_nz_next;
    logic [hdum_pkg::USAGE_W-1:0] page_lo_reg,     page_lo_next;
    logic                         page_ok_reg,     page_ok_next;
    logic [hdum_pkg::USAGE_W-1:0] usage_lo_reg,    usage_lo_next;
    logic                         usage_ok_reg,    usage_ok_next;
    logic                         found_reg,       found_next;

    // output register
    logic                         m_tvalid_reg,    m_tvalid_next;
    logic                         matched_reg,     matched_next;

    logic                         s_accept;

    // item completion
    logic                         apply_en;
    logic [7:0]                   apply_tag;
    logic [hdum_pkg::USAGE_W-1:0] apply_lo;
    logic                         apply_hi_nz;
    logic [7:0]                   prefix_tag;
    logic [1:0]                   len_code;
    logic [hdum_pkg::LEFT_W-1:0]  left_dec;

    // ------------------------------------------------------------------
    // apb port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_sel = hdum_pkg::cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_page_reg  <= '0;
            target_usage_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                hdum_pkg::REG_TARGET_PAGE:  target_page_reg  <= pwdata[hdum_pkg::USAGE_W-1:0];
                hdum_pkg::REG_TARGET_USAGE: target_usage_reg <= pwdata[hdum_pkg::USAGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            hdum_pkg::REG_TARGET_PAGE:
                prdata = {{(hdum_pkg::APB_DATA_W-hdum_pkg::USAGE_W){1'b0}}, target_page_reg};
            hdum_pkg::REG_TARGET_USAGE:
                prdata = {{(hdum_pkg::APB_DATA_W-hdum_pkg::USAGE_W){1'b0}}, target_usage_reg};
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stream handshake: take a byte whenever the output slot is free or
    // being emptied this cycle
    // ------------------------------------------------------------------
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign s_accept = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, matched_reg};

    assign prefix_tag = s_tdata & hdum_pkg::PREFIX_TAG_MASK;
    assign len_code   = s_tdata[1:0] & hdum_pkg::PREFIX_SIZE_MASK[1:0];
    assign left_dec   = bytes_left_reg - 1'b1;

    // ------------------------------------------------------------------
    // per-byte parse
    // ------------------------------------------------------------------
    always_comb begin
        bytes_left_next = bytes_left_reg;
        item_tag_next   = item_tag_reg;
        byte_pos_next   = byte_pos_reg;
        item_lo_next    = item_lo_reg;
        item_hi_nz_next = item_hi_nz_reg;
        page_lo_next    = page_lo_reg;
        page_ok_next    = page_ok_reg;
        usage_lo_next   = usage_lo_reg;
        usage_ok_next   = usage_ok_reg;
        found_next      = found_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        matched_next    = matched_reg;
        apply_en        = 1'b0;
        apply_tag       = prefix_tag;
        apply_lo        = '0;
        apply_hi_nz     = 1'b0;

        if (s_accept) begin
            if (bytes_left_reg == '0) begin
                // prefix byte
                item_tag_next   = s_tdata[7:2];
                byte_pos_next   = '0;
                item_lo_next    = '0;
                item_hi_nz_next = 1'b0;
                if (len_code == 2'd0) begin
                    apply_en = 1'b1;
                end else if (len_code == hdum_pkg::SIZE_CODE_FOUR) begin
                    bytes_left_next = 3'd4;
                end else begin
                    bytes_left_next = {1'b0, len_code};
                end
            end else begin
                // data byte, little-endian
                case (byte_pos_reg)
                    2'd0:    item_lo_next[7:0]  = s_tdata;
                    2'd1:    item_lo_next[15:8] = s_tdata;
                    default: item_hi_nz_next    = item_hi_nz_reg | (s_tdata != 8'd0);
                endcase
                byte_pos_next   = byte_pos_reg + 1'b1;
                bytes_left_next = left_dec;
                apply_tag       = {item_tag_reg, 2'b00};
                apply_lo        = item_lo_next;
                apply_hi_nz     = item_hi_nz_next;
                apply_en        = (left_dec == '0);
            end

            if (apply_en) begin
                case (apply_tag)
                    hdum_pkg::TAG_USAGE_PAGE: begin
                        page_lo_next = apply_lo;
                        page_ok_next = ~apply_hi_nz;
                    end
                    hdum_pkg::TAG_USAGE: begin
                        usage_lo_next = apply_lo;
                        usage_ok_next = ~apply_hi_nz;
                    end
                    hdum_pkg::TAG_COLLECTION: begin
                        if (page_ok_reg && usage_ok_reg &&
                            page_lo_reg == target_page_reg &&
                            usage_lo_reg == target_usage_reg) begin
                            found_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // last byte: report and start a fresh descriptor
            if (s_tlast) begin
                m_tvalid_next   = 1'b1;
                matched_next    = found_next;
                bytes_left_next = '0;
                item_tag_next   = '0;
                byte_pos_next   = '0;
                item_lo_next    = '0;
                item_hi_nz_next = 1'b0;
                page_lo_next    = '0;
                page_ok_next    = 1'b0;
                usage_lo_next   = '0;
                usage_ok_next   = 1'b0;
                found_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            item_tag_reg   <= '0;
            byte_pos_reg   <= '0;
            item_lo_reg    <= '0;
            item_hi_nz_reg <= 1'b0;
            page_lo_reg    <= '0;
            page_ok_reg    <= 1'b0;
            usage_lo_reg   <= '0;
            usage_ok_reg   <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            item_tag_reg   <= item_tag_next;
            byte_pos_reg   <= byte_pos_next;
            item_lo_reg    <= item_lo_next;
            item_hi_nz_reg <= item_hi_nz_next;
            page_lo_reg    <= page_lo_next;
            page_ok_reg    <= page_ok_next;
            usage_lo_reg   <= usage_lo_next;
            usage_ok_reg   <= usage_ok_next;
            found_reg      <= found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        matched_reg <= matched_next;
    end

endmodule

[tb/hid_descriptor_usage_matcher_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_descriptor_usage_matcher_unit_tb
// streams report descriptors through the matcher and checks every result beat
// against an in-bench short item parser, under random bursts, gaps and stalls
// ----------------------------------------------------------------------------
module hid_descriptor_usage_matcher_unit_tb;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int RAND_PHASES     = 8;
    localparam int BEATS_PER_PHASE = 100;
    localparam int PRESSURE_PHASE  = 3;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 4;

    // one descriptor byte as it travels on the input stream
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } desc_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;     // [7:0] desc_byte
    logic        s_tlast  = 1'b0;     // is_final
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;             // [0] matched, [7:1] zero

    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [hdum_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [hdum_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [hdum_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    hid_descriptor_usage_matcher_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // parser mirror: targets, parse state and the match flags still owed
    // ------------------------------------------------------------------------
    logic [15:0] tgt_page    = '0;
    logic [15:0] tgt_usage   = '0;
    logic [2:0]  parse_left  = '0;
    logic [5:0]  parse_tag   = '0;
    logic [1:0]  parse_pos   = '0;
    logic [31:0] parse_value = '0;
    logic [31:0] page_now    = '0;
    logic [31:0] usage_now   = '0;
    logic        page_valid  = 1'b0;
    logic        usage_valid = 1'b0;
    logic        coll_hit    = 1'b0;
    logic        match_flag_q[$];

    // stimulus store and counters
    desc_beat_t desc_stream_q[$];
    logic [7:0] desc_build_q[$];
    int         total_beats  = 0;
    int         beats_taken  = 0;
    int         desc_count   = 0;
    int         match_count  = 0;
    int         errors       = 0;
    int         idle_cycles  = 0;

    // flow control knobs, set per phase
    bit          tx_gaps_on  = 1'b0;
    int          tx_gap      = 0;
    int          tx_burst    = 0;
    logic [15:0] rx_pattern  = 16'hFFFF;
    bit          rx_hold_req = 1'b0;
    int          rx_hold_left = 0;

    logic       byte_taken = 1'b0;
    logic       exp_flag;
    desc_beat_t beat_next;

    // one accepted descriptor byte through the short item parser
    task automatic parse_desc_byte(input logic [7:0] b_in, input logic fin);
        logic       done;
        logic [7:0] tag_byte;
        done = 1'b0;
        if (parse_left == '0) begin
            // prefix byte: tag in the upper six bits, size code below
            parse_tag   = 6'((b_in & hdum_pkg::PREFIX_TAG_MASK) >> 2);
            parse_pos   = '0;
            parse_value = '0;
            if ((b_in & hdum_pkg::PREFIX_SIZE_MASK) == 8'd0) begin
                done = 1'b1;
            end else if (b_in[1:0] == hdum_pkg::SIZE_CODE_FOUR) begin
                parse_left = 3'd4;
            end else begin
                parse_left = {1'b0, b_in[1:0]};
            end
        end else begin
            // data bytes land little-endian
            parse_value = parse_value | (32'(b_in) << (8 * parse_pos));
            parse_pos   = parse_pos + 2'd1;
            parse_left  = parse_left - 3'd1;
            done        = (parse_left == '0);
        end
        if (done) begin
            tag_byte = {parse_tag, 2'b00};
            if (tag_byte == hdum_pkg::TAG_USAGE_PAGE) begin
                page_now   = parse_value;
                page_valid = 1'b1;
            end else if (tag_byte == hdum_pkg::TAG_USAGE) begin
                usage_now   = parse_value;
                usage_valid = 1'b1;
            end else if (tag_byte == hdum_pkg::TAG_COLLECTION) begin
                // full 32 bit compare, so wide values never hit
                if (page_valid && usage_valid && page_now == {16'd0, tgt_page} &&
                        usage_now == {16'd0, tgt_usage})
                    coll_hit = 1'b1;
            end
        end
        if (fin) begin
            // an item still open here was cut short and is dropped
            match_flag_q.push_back(coll_hit);
            parse_left  = '0;
            parse_tag   = '0;
            parse_pos   = '0;
            parse_value = '0;
            page_now    = '0;
            usage_now   = '0;
            page_valid  = 1'b0;
            usage_valid = 1'b0;
            coll_hit    = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // input driver: bursts of random length with random gaps in between
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_tvalid || byte_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (desc_stream_q.size() != 0) begin
                beat_next = desc_stream_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= beat_next.data;
                s_tlast  <= beat_next.fin;
                if (tx_burst > 0) begin
                    tx_burst--;
                end else begin
                    tx_burst = $urandom_range(1, 24);
                    tx_gap   = tx_gaps_on ? $urandom_range(1, 8) : 0;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side ready: rotating stall pattern, plus one long hold-off on
    // request so the pending result backs up into the input
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks result beats, feeds accepted bytes to the parser mirror,
    // and ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            byte_taken = s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (match_flag_q.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none owed, expected none, got %02h",
                             $time, m_tdata);
                end else begin
                    exp_flag = match_flag_q.pop_front();
                    if (m_tdata !== {7'd0, exp_flag}) begin
                        errors++;
                        $display("%0t: matched mismatch, expected %02h, got %02h",
                                 $time, {7'd0, exp_flag}, m_tdata);
                    end
                    if (exp_flag)
                        match_count++;
                end
            end
            if (byte_taken) begin
                parse_desc_byte(s_tdata, s_tlast);
                beats_taken++;
                if (s_tlast)
                    desc_count++;
            end
            if (byte_taken || (m_tvalid && m_tready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("hid_descriptor_usage_matcher_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // apb write of one target, then a read-back of the same register
    task automatic write_target(input hdum_pkg::cfg_reg_t idx, input logic [15:0] val);
        logic [31:0] rd;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};   // upper bits must be dropped
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == hdum_pkg::REG_TARGET_PAGE)
            tgt_page = val;
        else
            tgt_usage = val;
        if (rd !== {16'd0, val}) begin
            errors++;
            $display("%0t: target read-back at %0d, expected %08h, got %08h",
                     $time, idx, {16'd0, val}, rd);
        end
    endtask

    // hands the built descriptor to the driver, last byte flagged
    task automatic send_descriptor();
        desc_beat_t beat;
        foreach (desc_build_q[k]) begin
            beat.data = desc_build_q[k];
            beat.fin  = (k == desc_build_q.size() - 1);
            desc_stream_q.push_back(beat);
            total_beats++;
        end
        desc_build_q.delete();
    endtask

    // short item with a size code that fits the value, sometimes wider
    task automatic add_short_item(input logic [7:0] tag8, input logic [31:0] val);
        logic [1:0] code;
        int         n;
        if (val > 32'hFFFF)
            code = hdum_pkg::SIZE_CODE_FOUR;
        else if (val > 32'hFF)
            code = 2'($urandom_range(2, 3));
        else if (val != 0)
            code = 2'($urandom_range(1, 3));
        else
            code = 2'($urandom_range(0, 3));
        n = (code == hdum_pkg::SIZE_CODE_FOUR) ? 4 : int'(code);
        desc_build_q.push_back(tag8 | {6'd0, code});
        for (int k = 0; k < n; k++)
            desc_build_q.push_back(val[8*k +: 8]);
    endtask

    // mostly the target, else near misses, wide values and junk
    function automatic logic [31:0] pick_value(input logic [15:0] tgt);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return {16'd0, tgt};
        else if (r < 7)
            return 32'($urandom_range(0, 65535));
        else if (r == 7)
            return 32'($urandom_range(0, 3));
        else if (r == 8)
            return {16'($urandom_range(1, 65535)), tgt};
        else
            return $urandom;
    endfunction

    // well-formed items with random content, a little noise, and now and
    // then a trailing item that the last byte cuts off
    task automatic queue_random_descriptor();
        int         n_items;
        int         pick;
        int         n_data;
        logic [7:0] prefix;
        n_items = $urandom_range(1, 10);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                add_short_item(hdum_pkg::TAG_USAGE_PAGE, pick_value(tgt_page));
            else if (pick < 50)
                add_short_item(hdum_pkg::TAG_USAGE, pick_value(tgt_usage));
            else if (pick < 72)
                add_short_item(hdum_pkg::TAG_COLLECTION, 32'($urandom_range(0, 255)));
            else if (pick < 90)
                add_short_item(8'($urandom) & hdum_pkg::PREFIX_TAG_MASK, $urandom);
            else
                desc_build_q.push_back(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       prefix = hdum_pkg::TAG_COLLECTION;
                1:       prefix = hdum_pkg::TAG_USAGE;
                2:       prefix = hdum_pkg::TAG_USAGE_PAGE;
                default: prefix = 8'($urandom) & hdum_pkg::PREFIX_TAG_MASK;
            endcase
            prefix = prefix | 8'($urandom_range(1, 3));
            n_data = (prefix[1:0] == hdum_pkg::SIZE_CODE_FOUR) ? 4 : int'(prefix[1:0]);
            desc_build_q.push_back(prefix);
            repeat ($urandom_range(0, n_data - 1))
                desc_build_q.push_back(8'($urandom));
        end
        send_descriptor();
    endtask

    // waits until every queued byte is in and every result is out
    task automatic drain();
        while (beats_taken != total_beats || match_flag_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int goal;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset targets are zero: a page alone does not qualify a collection
        desc_build_q = '{8'hA0, 8'h04, 8'hA0};
        send_descriptor();
        drain();

        write_target(hdum_pkg::REG_TARGET_PAGE, 16'h0001);
        write_target(hdum_pkg::REG_TARGET_USAGE, 16'h0006);
        // collection completed by its data byte on the last beat
        desc_build_q = '{8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01};
        send_descriptor();
        // wide page misses, narrow page hits, later usage does not clear the
        // flag, and a four byte item of another tag is cut off at the end
        desc_build_q = '{8'h07, 8'h01, 8'h00, 8'h01, 8'h00, 8'h09, 8'h06, 8'hA0,
                         8'h05, 8'h01, 8'hA0, 8'h09, 8'h07, 8'hA0, 8'hFF, 8'hFF};
        send_descriptor();
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_target(hdum_pkg::REG_TARGET_PAGE, 16'hFFFF);
                    write_target(hdum_pkg::REG_TARGET_USAGE, 16'hFFFF);
                end
                1: begin
                    write_target(hdum_pkg::REG_TARGET_USAGE, 16'hFFFF);
                    write_target(hdum_pkg::REG_TARGET_PAGE, 16'h0000);
                end
                2: begin
                    write_target(hdum_pkg::REG_TARGET_PAGE, 16'hFFFF);
                    write_target(hdum_pkg::REG_TARGET_USAGE, 16'h0000);
                end
                default: begin
                    // half the time small enough for one byte items
                    write_target(hdum_pkg::REG_TARGET_PAGE, $urandom_range(0, 1) ?
                                 16'($urandom_range(0, 255)) : 16'($urandom));
                    write_target(hdum_pkg::REG_TARGET_USAGE, $urandom_range(0, 1) ?
                                 16'($urandom_range(0, 255)) : 16'($urandom));
                end
            endcase
            // every third phase runs with no idling on either side, but for the result hold-off of the pressure phase
            tx_gaps_on = (ph % 3 != 0) && (ph != PRESSURE_PHASE);
            rx_pattern = (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            if (ph == PRESSURE_PHASE)
                rx_hold_req = 1'b1;
            goal = total_beats + BEATS_PER_PHASE;
            while (total_beats < goal)
                queue_random_descriptor();
            drain();
        end

        $display("sent %0d descriptor bytes in %0d descriptors over %0d target settings,",
                 beats_taken, desc_count, RAND_PHASES + 2);
        $display("%0d descriptors matched, %0d mismatches", match_count, errors);
        if (errors == 0)
            $display("hid_descriptor_usage_matcher_unit_tb OK");
        else
            $display("hid_descriptor_usage_matcher_unit_tb NOT OK");
        $finish;
    end

endmodule
